// ===== rtl/space_packet_framer_crc16_macros.svh =====
// Assertion macros shared by the space packet framer RTL.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef SPACE_PACKET_FRAMER_CRC16_MACROS_SVH
`define SPACE_PACKET_FRAMER_CRC16_MACROS_SVH

// Same-cycle implication.
`define SPF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spf assertion failed");

// Next-cycle implication.
`define SPF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spf assertion failed");

`endif

// ===== rtl/spf_pkg.sv =====
// Package for the space packet framer: item types, byte sequence codes,
// register indexes, reset values and the CRC-16 byte update. No dependencies.
`default_nettype none

package spf_pkg;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        start_packet;
        logic [13:0] seq_count;
        logic [15:0] payload_length;
    } t_in_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } t_out_item;

    // Position of the next frame byte within the work on one input item.
    typedef logic [3:0] t_idx;

    localparam t_idx IDX_SYNC0  = 4'd0;
    localparam t_idx IDX_SYNC1  = 4'd1;
    localparam t_idx IDX_SYNC2  = 4'd2;
    localparam t_idx IDX_SYNC3  = 4'd3;
    localparam t_idx IDX_APID_H = 4'd4;
    localparam t_idx IDX_APID_L = 4'd5;
    localparam t_idx IDX_SEQ_H  = 4'd6;
    localparam t_idx IDX_SEQ_L  = 4'd7;
    localparam t_idx IDX_LEN_H  = 4'd8;
    localparam t_idx IDX_LEN_L  = 4'd9;
    localparam t_idx IDX_DATA   = 4'd10;
    localparam t_idx IDX_CRC_H  = 4'd11;
    localparam t_idx IDX_CRC_L  = 4'd12;

    localparam logic CFG_SYNC_WORD = 1'b0;
    localparam logic CFG_APP_ID    = 1'b1;

    localparam logic [31:0] SYNC_RESET   = 32'hC830_FAFE;
    localparam logic [8:0]  APP_ID_RESET = 9'd0;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'h1021;

    // CRC-16 CCITT update over one byte, MSB first, no reflection.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/spf_byte_gen.sv =====
// Frame byte generator: picks the byte for the current sequence position and
// computes the CRC after it. Depends on spf_pkg.
`default_nettype none

module spf_byte_gen (
    input  wire spf_pkg::t_in_item i_item,
    input  wire spf_pkg::t_idx     i_idx,
    input  wire logic [31:0]       i_sync_word,
    input  wire logic [8:0]        i_app_id,
    input  wire logic [15:0]       i_crc,
    output logic [7:0]             o_byte,
    output logic [15:0]            o_crc_next
);

    logic [15:0] len_word;
    logic [15:0] crc_base;

    assign len_word = 16'(i_item.payload_length - 16'd1);

    always_comb begin
        unique case (i_idx)
            spf_pkg::IDX_SYNC0:  o_byte = i_sync_word[31:24];
            spf_pkg::IDX_SYNC1:  o_byte = i_sync_word[23:16];
            spf_pkg::IDX_SYNC2:  o_byte = i_sync_word[15:8];
            spf_pkg::IDX_SYNC3:  o_byte = i_sync_word[7:0];
            spf_pkg::IDX_APID_H: o_byte = {7'b0000_100, i_app_id[8]};
            spf_pkg::IDX_APID_L: o_byte = i_app_id[7:0];
            spf_pkg::IDX_SEQ_H:  o_byte = {2'b11, i_item.seq_count[13:8]};
            spf_pkg::IDX_SEQ_L:  o_byte = i_item.seq_count[7:0];
            spf_pkg::IDX_LEN_H:  o_byte = len_word[15:8];
            spf_pkg::IDX_LEN_L:  o_byte = len_word[7:0];
            spf_pkg::IDX_DATA:   o_byte = i_item.payload_byte;
            spf_pkg::IDX_CRC_H:  o_byte = i_crc[15:8];
            spf_pkg::IDX_CRC_L:  o_byte = i_crc[7:0];
            default:             o_byte = 8'h00;
        endcase
    end

    // The CRC restarts on the first sync byte of every frame.
    assign crc_base   = (i_idx == spf_pkg::IDX_SYNC0) ? spf_pkg::CRC_INIT : i_crc;
    assign o_crc_next = spf_pkg::crc_byte(crc_base, o_byte);

endmodule

`default_nettype wire

// ===== rtl/space_packet_framer_crc16.sv =====
// Space packet framer with CRC-16 CCITT: top level. Depends on spf_pkg,
// spf_byte_gen and space_packet_framer_crc16_macros.svh.
//
// One frame byte leaves per cycle through the output register unless the
// receiver stalls; an item is held until it has emitted its bytes: one for
// a payload byte inside a packet, 11 for a byte that opens a packet, 2 more
// when a byte closes a packet (the CRC high and low bytes), none for a byte
// dropped outside a packet. Mid-packet payload bytes flow at one transaction
// per cycle unless stalled; o_in_ready follows i_out_ready in the same cycle.
// A start transaction restarts the frame even inside an open packet.
// Configuration writes are taken every cycle and must be made while idle.
`default_nettype none

`include "space_packet_framer_crc16_macros.svh"

module space_packet_framer_crc16 (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire spf_pkg::t_in_item i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output spf_pkg::t_out_item     o_out,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic              i_cfg_index,
    input  wire logic [31:0]       i_cfg_data
);

    logic [31:0]       r_sync_word;
    logic [8:0]        r_app_id;
    logic              r_hold_vld, n_hold_vld;
    spf_pkg::t_in_item r_item;
    spf_pkg::t_idx     r_idx, n_idx;
    logic [15:0]       r_bytes_left, n_bytes_left;
    logic [15:0]       r_crc, n_crc;
    logic              r_out_vld, n_out_vld;
    spf_pkg::t_out_item r_out;

    logic        out_free;
    logic        drop;
    logic        emit;
    logic        last;
    logic        retire;
    logic        accept;
    logic [15:0] bl_next;
    logic [7:0]  gen_byte;
    logic [15:0] gen_crc;

    spf_byte_gen u_byte_gen (
        .i_item      (r_item),
        .i_idx       (r_idx),
        .i_sync_word (r_sync_word),
        .i_app_id    (r_app_id),
        .i_crc       (r_crc),
        .o_byte      (gen_byte),
        .o_crc_next  (gen_crc)
    );

    always_comb begin
        out_free = !r_out_vld || i_out_ready;
        drop     = r_hold_vld && !r_item.start_packet && (r_idx == spf_pkg::IDX_DATA)
                   && (r_bytes_left == 16'd0);
        bl_next  = r_item.start_packet ? 16'(r_item.payload_length - 16'd1)
                                       : 16'(r_bytes_left - 16'd1);
        emit     = r_hold_vld && !drop && out_free;
        last     = (r_idx == spf_pkg::IDX_CRC_L)
                   || ((r_idx == spf_pkg::IDX_DATA) && (bl_next != 16'd0));
        retire   = drop || (emit && last);
        o_in_ready = !r_hold_vld || retire;
        accept   = i_in_valid && o_in_ready;
    end

    always_comb begin
        n_hold_vld   = r_hold_vld;
        n_idx        = r_idx;
        n_bytes_left = r_bytes_left;
        n_crc        = r_crc;
        n_out_vld    = r_out_vld;
        if (accept) begin
            n_hold_vld = 1'b1;
            n_idx      = i_in.start_packet ? spf_pkg::IDX_SYNC0 : spf_pkg::IDX_DATA;
        end else if (retire) begin
            n_hold_vld = 1'b0;
        end else if (emit) begin
            n_idx = spf_pkg::t_idx'(r_idx + 4'd1);
        end
        // The CRC covers header and payload bytes, never its own bytes.
        if (emit && (r_idx <= spf_pkg::IDX_DATA)) begin
            n_crc = gen_crc;
        end
        if (emit && (r_idx == spf_pkg::IDX_DATA)) begin
            n_bytes_left = bl_next;
        end
        if (emit) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_word  <= spf_pkg::SYNC_RESET;
            r_app_id     <= spf_pkg::APP_ID_RESET;
            r_hold_vld   <= 1'b0;
            r_idx        <= spf_pkg::IDX_SYNC0;
            r_bytes_left <= 16'd0;
            r_crc        <= spf_pkg::CRC_INIT;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    spf_pkg::CFG_SYNC_WORD: r_sync_word <= i_cfg_data;
                    spf_pkg::CFG_APP_ID:    r_app_id    <= i_cfg_data[8:0];
                    default:                r_app_id    <= r_app_id;
                endcase
            end
            r_hold_vld   <= n_hold_vld;
            r_idx        <= n_idx;
            r_bytes_left <= n_bytes_left;
            r_crc        <= n_crc;
            r_out_vld    <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in;
        end
        if (emit) begin
            r_out.frame_byte <= gen_byte;
            r_out.frame_end  <= (r_idx == spf_pkg::IDX_CRC_L);
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // A frame end always closes the packet.
    `SPF_ASSERT_IMP(a_end_closes, r_out_vld && r_out.frame_end, r_bytes_left == 16'd0)
    // The sequence position never runs past the CRC low byte.
    `SPF_ASSERT_IMP(a_idx_range, r_hold_vld, r_idx <= spf_pkg::IDX_CRC_L)
    // Emitting the CRC leaves the CRC register untouched.
    `SPF_ASSERT_NXT(a_crc_hold, emit && (r_idx > spf_pkg::IDX_DATA), r_crc == $past(r_crc))
    // The low CRC byte is the last byte of the frame and is flagged.
    `SPF_ASSERT_NXT(a_end_flag, emit && (r_idx == spf_pkg::IDX_CRC_L),
        r_out_vld && r_out.frame_end)

endmodule

`default_nettype wire

// ===== verif/space_packet_framer_crc16_tb.sv =====
// Self-checking testbench for space_packet_framer_crc16: directed rows, then
// random packet streams under changing settings.
// Depends on spf_pkg and the framer RTL; every frame byte is checked in order.
module space_packet_framer_crc16_tb;

    localparam int          HALF_PERIOD   = 5;
    localparam int          TIMEOUT       = 10_000_000;
    localparam int          HOLD_CYCLES   = 300;
    // A dropped byte keeps the block busy without producing a byte.
    localparam int          SETTLE_CYCLES = 4;
    localparam int          N_DIRECTED    = 19;
    localparam int          PHASE_ITEMS   = 44;
    localparam logic [15:0] SEC_HDR_FLAG  = 16'h0800;
    localparam logic [1:0]  GROUPING      = 2'b11;

    // How the expected bytes of a directed row are obtained.
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_DROP,
        ROW_HDR
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [7:0]  data;
        logic        st;
        logic [13:0] seq;
        logic [15:0] len;
        logic [79:0] hdr;
    } t_dir_row;

    // Header bytes are typed in for packet openings under the reset settings.
    localparam t_dir_row DIR_ROWS [N_DIRECTED] = '{
        '{ROW_DROP,    8'h00, 1'b0, 14'h0000, 16'h0000, 80'h0},
        '{ROW_DROP,    8'hFF, 1'b0, 14'h3FFF, 16'hFFFF, 80'h0},
        '{ROW_HDR,     8'h00, 1'b1, 14'h0000, 16'h0001, 80'hC830FAFE_0800_C000_0000},
        '{ROW_HDR,     8'hFF, 1'b1, 14'h3FFF, 16'h0001, 80'hC830FAFE_0800_FFFF_0000},
        '{ROW_HDR,     8'hA5, 1'b1, 14'h1555, 16'h0003, 80'hC830FAFE_0800_D555_0002},
        '{ROW_PREDICT, 8'h5A, 1'b0, 14'h3FFF, 16'hFFFF, 80'h0},
        '{ROW_PREDICT, 8'hFF, 1'b0, 14'h2AAA, 16'h5555, 80'h0},
        '{ROW_DROP,    8'h81, 1'b0, 14'h1555, 16'hAAAA, 80'h0},
        '{ROW_HDR,     8'h01, 1'b1, 14'h2AAA, 16'h0004, 80'hC830FAFE_0800_EAAA_0003},
        '{ROW_PREDICT, 8'h02, 1'b0, 14'h0000, 16'h0000, 80'h0},
        '{ROW_HDR,     8'h10, 1'b1, 14'h0001, 16'h0002, 80'hC830FAFE_0800_C001_0001},
        '{ROW_PREDICT, 8'h20, 1'b0, 14'h3FFF, 16'h0001, 80'h0},
        '{ROW_HDR,     8'h33, 1'b1, 14'h0ABC, 16'h0000, 80'hC830FAFE_0800_CABC_FFFF},
        '{ROW_PREDICT, 8'h44, 1'b0, 14'h0000, 16'hFFFF, 80'h0},
        '{ROW_PREDICT, 8'h55, 1'b0, 14'h3FFF, 16'h0000, 80'h0},
        '{ROW_HDR,     8'h66, 1'b1, 14'h3FFE, 16'hFFFF, 80'hC830FAFE_0800_FFFE_FFFE},
        '{ROW_PREDICT, 8'h77, 1'b0, 14'h1234, 16'h4321, 80'h0},
        '{ROW_HDR,     8'h88, 1'b1, 14'h0002, 16'h0002, 80'hC830FAFE_0800_C002_0001},
        '{ROW_PREDICT, 8'h99, 1'b0, 14'h0000, 16'h0000, 80'h0}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    spf_pkg::t_in_item   i_in;
    logic                o_out_valid;
    logic                i_out_ready;
    spf_pkg::t_out_item  o_out;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic                i_cfg_index;
    logic [31:0]         i_cfg_data;

    // Framer model state and settings.
    logic [31:0]         sync_cfg;
    logic [8:0]          apid_cfg;
    logic [15:0]         pkt_left;
    logic [15:0]         crc_run;
    spf_pkg::t_out_item  step_buf [13];
    int                  step_n;

    spf_pkg::t_out_item  pending_bytes [$];
    int                  bad_cnt;
    int                  busy_items;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  hold_asked;
    int                  hold_served;

    space_packet_framer_crc16 u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Bit-serial CRC-16 CCITT update, data MSB first.
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? spf_pkg::CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic void put_frame_byte(input logic [7:0] b, input bit fold, input bit last);
        step_buf[step_n].frame_byte = b;
        step_buf[step_n].frame_end  = last;
        step_n++;
        if (fold) begin
            crc_run = crc16_update(crc_run, b);
        end
    endfunction

    // Computes the frame bytes that one accepted item produces into step_buf.
    function automatic void frame_bytes_for(input spf_pkg::t_in_item it);
        logic [15:0] apid_w;
        logic [15:0] seq_w;
        logic [15:0] len_w;
        step_n = 0;
        if (it.start_packet) begin
            apid_w  = {7'd0, apid_cfg} | SEC_HDR_FLAG;
            seq_w   = {GROUPING, it.seq_count};
            len_w   = it.payload_length - 16'd1;
            crc_run = spf_pkg::CRC_INIT;
            for (int k = 3; k >= 0; k--) begin
                put_frame_byte(sync_cfg[8*k +: 8], 1'b1, 1'b0);
            end
            put_frame_byte(apid_w[15:8], 1'b1, 1'b0);
            put_frame_byte(apid_w[7:0], 1'b1, 1'b0);
            put_frame_byte(seq_w[15:8], 1'b1, 1'b0);
            put_frame_byte(seq_w[7:0], 1'b1, 1'b0);
            put_frame_byte(len_w[15:8], 1'b1, 1'b0);
            put_frame_byte(len_w[7:0], 1'b1, 1'b0);
            put_frame_byte(it.payload_byte, 1'b1, 1'b0);
            pkt_left = len_w;
        end else if (pkt_left != 16'd0) begin
            put_frame_byte(it.payload_byte, 1'b1, 1'b0);
            pkt_left = pkt_left - 16'd1;
        end
        if (step_n != 0 && pkt_left == 16'd0) begin
            put_frame_byte(crc_run[15:8], 1'b0, 1'b0);
            put_frame_byte(crc_run[7:0], 1'b0, 1'b1);
        end
    endfunction

    function automatic spf_pkg::t_in_item rand_item(input logic st);
        spf_pkg::t_in_item it;
        it.payload_byte   = 8'($urandom);
        it.start_packet   = st;
        it.seq_count      = 14'($urandom);
        it.payload_length = 16'($urandom);
        return it;
    endfunction

    // Offers one item, waits for its transaction and queues the bytes it causes.
    task automatic push_item(input spf_pkg::t_in_item it, input t_row_kind kind,
                             input logic [79:0] hdr);
        spf_pkg::t_out_item ob;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (!o_in_ready);
        frame_bytes_for(it);
        if (step_n != 0) begin
            busy_items++;
        end
        for (int k = 0; k < step_n; k++) begin
            ob = step_buf[k];
            if (kind == ROW_HDR && k < 10) begin
                ob.frame_byte = hdr[79 - 8*k -: 8];
                ob.frame_end  = 1'b0;
            end
            if (kind != ROW_DROP) begin
                pending_bytes.push_back(ob);
            end
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == spf_pkg::CFG_SYNC_WORD) begin
            sync_cfg = val;
        end else begin
            apid_cfg = val[8:0];
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed packets of small size with random content; some are cut
    // short by a restart, some have a huge length, and stray bytes fall between.
    task automatic run_random(input int goal);
        int first;
        int len;
        int conts;
        int stray;
        int r;
        first = busy_items;
        while (busy_items - first < goal) begin
            stray = ($urandom_range(99) < 15) ? $urandom_range(1, 3) : 0;
            for (int k = 0; k < stray; k++) begin
                push_item(rand_item(1'b0), ROW_PREDICT, '0);
            end
            r = $urandom_range(99);
            if (r < 80) begin
                len = $urandom_range(1, 6);
            end else if (r < 90) begin
                len = $urandom_range(7, 40);
            end else begin
                len = $urandom_range(65535, 0);
            end
            if (len > 40 || len == 0) begin
                conts = $urandom_range(0, 4);
            end else if (len > 1 && $urandom_range(99) < 10) begin
                conts = $urandom_range(0, len - 2);
            end else begin
                conts = len - 1;
            end
            begin
                spf_pkg::t_in_item it;
                it                = rand_item(1'b1);
                it.payload_length = 16'(len);
                push_item(it, ROW_PREDICT, '0);
            end
            for (int k = 0; k < conts; k++) begin
                push_item(rand_item(1'b0), ROW_PREDICT, '0);
            end
        end
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial begin : out_side
        int hold_left;
        hold_left   = 0;
        hold_served = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_asked) begin
                hold_left   = HOLD_CYCLES;
                hold_served = hold_asked;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        spf_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_bytes.size() == 0) begin
                bad_cnt++;
                $display("%0t: unexpected frame byte: expected none, got %h end=%b",
                         $time, o_out.frame_byte, o_out.frame_end);
            end else begin
                want = pending_bytes.pop_front();
                if (o_out.frame_byte !== want.frame_byte || o_out.frame_end !== want.frame_end)
                begin
                    bad_cnt++;
                    $display("%0t: frame byte mismatch: expected %h end=%b, got %h end=%b",
                             $time, want.frame_byte, want.frame_end,
                             o_out.frame_byte, o_out.frame_end);
                end
            end
        end
    end

    initial begin
        #(TIMEOUT);
        $display("space_packet_framer_crc16_tb: done, errors");
        $finish;
    end

    initial begin : main_seq
        spf_pkg::t_in_item it;
        int                guard;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in           = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = spf_pkg::CFG_SYNC_WORD;
        i_cfg_data     = '0;
        bad_cnt        = 0;
        busy_items     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_asked     = 0;
        sync_cfg       = spf_pkg::SYNC_RESET;
        apid_cfg       = spf_pkg::APP_ID_RESET;
        pkt_left       = 16'd0;
        crc_run        = spf_pkg::CRC_INIT;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIRECTED; r++) begin
            it.payload_byte   = DIR_ROWS[r].data;
            it.start_packet   = DIR_ROWS[r].st;
            it.seq_count      = DIR_ROWS[r].seq;
            it.payload_length = DIR_ROWS[r].len;
            push_item(it, DIR_ROWS[r].kind, DIR_ROWS[r].hdr);
        end
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    write_reg(spf_pkg::CFG_SYNC_WORD, 32'h0000_0000);
                    write_reg(spf_pkg::CFG_APP_ID, 32'hFFFF_FFFF);
                end
                1: begin
                    send_idle_pct  = 64;
                    recv_stall_pct = 0;
                    write_reg(spf_pkg::CFG_SYNC_WORD, 32'hFFFF_FFFF);
                    write_reg(spf_pkg::CFG_APP_ID, 32'h0000_0000);
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 64;
                    write_reg(spf_pkg::CFG_SYNC_WORD, $urandom);
                    write_reg(spf_pkg::CFG_APP_ID, $urandom);
                end
                default: begin
                    send_idle_pct  = 13;
                    recv_stall_pct = 13;
                    write_reg(spf_pkg::CFG_SYNC_WORD, spf_pkg::SYNC_RESET);
                    write_reg(spf_pkg::CFG_APP_ID, $urandom);
                end
            endcase
            if (ph == 0) begin
                // The output side holds off while items keep coming, so the input stalls.
                hold_asked++;
                run_random(PHASE_ITEMS);
            end else if (ph == 1) begin
                run_random(PHASE_ITEMS / 2);
                wait_idle();
                run_random(PHASE_ITEMS / 2);
            end else begin
                run_random(PHASE_ITEMS);
            end
            wait_idle();
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        guard = 0;
        while (pending_bytes.size() != 0 && guard < 100_000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (pending_bytes.size() != 0) begin
            $display("%0t: %0d frame bytes never arrived", $time, pending_bytes.size());
        end
        if (bad_cnt == 0 && pending_bytes.size() == 0) begin
            $display("space_packet_framer_crc16_tb: done, clean");
        end else begin
            $display("space_packet_framer_crc16_tb: done, errors");
        end
        $finish;
    end

endmodule
